// ----- hdl/cde_pkg.sv -----
package cde_pkg;

	localparam int DIGIT_W     = 4;
	localparam int PACK_DIGITS = 13;
	localparam int PACKED_W    = DIGIT_W * PACK_DIGITS;

	// Key codes carried in the kind field
	localparam logic [2:0] KIND_CLEAR = 3'd0;
	localparam logic [2:0] KIND_BACK  = 3'd1;
	localparam logic [2:0] KIND_POINT = 3'd2;
	localparam logic [2:0] KIND_SIGN  = 3'd3;
	localparam logic [2:0] KIND_DIGIT = 3'd4;

	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
	localparam logic [DIGIT_W-1:0] DIGIT_TOP  = 4'd9;

	typedef struct packed {
		logic [2:0]         kind;
		logic [DIGIT_W-1:0] digit;
	} key_t;

	typedef struct packed {
		logic [PACKED_W-1:0] digits_packed;
		logic [3:0]          digit_count;
		logic [3:0]          point_position;
		logic                negative;
		logic                entry_full;
	} result_t;

	// Command broadcast to every digit cell
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_PUSH,
		OP_POP,
		OP_SET
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [DIGIT_W-1:0] data;
	} cell_cmd_t;

	// Entry status after the current key
	typedef struct packed {
		logic [3:0] digit_count;
		logic [3:0] point_position;
		logic       negative;
		logic       entry_full;
	} entry_status_t;

endpackage

// ----- hdl/cde_cell.sv -----
module cde_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cde_pkg::cell_cmd_t         cmd,
	input  logic                       head,
	input  logic                       left_last,
	input  logic                       right_last,
	output logic                       last,
	output logic [cde_pkg::DIGIT_W-1:0] digit,
	output logic [cde_pkg::DIGIT_W-1:0] digit_nxt
);
	import cde_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic               mark_q;
	logic               last_nxt;

	// The head cell stores its tail mark inverted, so a plain reset leaves
	// the tail on the head cell.
	assign last  = mark_q ^ head;
	assign digit = digit_q;

	always_comb begin
		digit_nxt = digit_q;
		last_nxt  = last;
		case (cmd.op)
			OP_CLEAR: begin
				digit_nxt = DIGIT_ZERO;
				last_nxt  = head;
			end
			OP_PUSH: begin
				// take the tail from the left neighbor
				if (left_last) begin
					digit_nxt = cmd.data;
				end
				last_nxt = left_last;
			end
			OP_POP: begin
				// drop the tail digit, hand the tail back left
				if (last) begin
					digit_nxt = DIGIT_ZERO;
				end
				last_nxt = right_last;
			end
			OP_SET: begin
				if (last) begin
					digit_nxt = cmd.data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= DIGIT_ZERO;
			mark_q  <= 1'b0;
		end else begin
			digit_q <= digit_nxt;
			mark_q  <= last_nxt ^ head;
		end
	end

endmodule

// ----- hdl/cde_ctrl.sv -----
module cde_ctrl #(
	parameter int MAX_DIGITS = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  cde_pkg::key_t               key,
	input  logic [cde_pkg::DIGIT_W-1:0] head_digit,
	output cde_pkg::cell_cmd_t          cmd,
	output cde_pkg::entry_status_t      status
);
	import cde_pkg::*;

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_DIGITS);

	logic [CW-1:0] count_q, count_nxt;
	logic [CW-1:0] point_q, point_nxt;
	logic          sign_q, sign_nxt;

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.data  = key.digit;
		count_nxt = count_q;
		point_nxt = point_q;
		sign_nxt  = sign_q;
		if (take) begin
			case (key.kind)
				KIND_CLEAR: begin
					cmd.op    = OP_CLEAR;
					count_nxt = ONE;
					point_nxt = '0;
					sign_nxt  = 1'b0;
				end
				KIND_BACK: begin
					if (point_q != '0 && point_q == count_q) begin
						point_nxt = '0;
					end else if (count_q > ONE) begin
						cmd.op    = OP_POP;
						count_nxt = count_q - ONE;
					end else begin
						// lone digit turns into zero
						cmd.op   = OP_SET;
						cmd.data = DIGIT_ZERO;
					end
				end
				KIND_POINT: begin
					if (point_q == '0) begin
						point_nxt = count_q;
					end
				end
				KIND_SIGN: begin
					sign_nxt = ~sign_q;
				end
				KIND_DIGIT: begin
					if (key.digit <= DIGIT_TOP && count_q < MAXC) begin
						if (point_q == '0 && count_q == ONE && head_digit == DIGIT_ZERO) begin
							cmd.op = OP_SET;
						end else begin
							cmd.op    = OP_PUSH;
							count_nxt = count_q + ONE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ONE;
			point_q <= '0;
			sign_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			point_q <= point_nxt;
			sign_q  <= sign_nxt;
		end
	end

	assign status.digit_count    = 4'(count_nxt);
	assign status.point_position = 4'(point_nxt);
	assign status.negative       = sign_nxt;
	assign status.entry_full     = (count_nxt >= MAXC);

endmodule

// ----- hdl/calculator_digit_entry.sv -----
// Channel | Handshake          | Payload              | Direction
// key     | key_valid/key_stall | cde_pkg::key_t      | in
// res     | res_valid/res_stall | cde_pkg::result_t   | out
//
// One key per cycle while key_stall is low: a key is applied to the digit cells
// and the entry registers at the edge that accepts it; its result is registered
// at that same edge, into the output register that drives res or else into skid.
// Reset clears the entry to a single zero digit, no point, plus sign.
// A two-entry output queue (output register plus skid register) parts the
// channels: key_stall rises only once both entries hold a waiting result.
module calculator_digit_entry #(
	parameter int MAX_DIGITS = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_valid,
	output logic             key_stall,
	input  cde_pkg::key_t    key_data,
	output logic             res_valid,
	input  logic             res_stall,
	output cde_pkg::result_t res_data
);
	import cde_pkg::*;

	// Only the first PACK_DIGITS digits reach the packed field
	localparam int NP = (MAX_DIGITS < PACK_DIGITS) ? MAX_DIGITS : PACK_DIGITS;

	logic                take;
	cell_cmd_t           cmd;
	entry_status_t       status;
	logic                last      [MAX_DIGITS];
	logic [DIGIT_W-1:0]  digit     [MAX_DIGITS];
	logic [DIGIT_W-1:0]  digit_nxt [MAX_DIGITS];
	result_t             result;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    pop;

	assign key_stall = skid_valid_q;
	assign take      = key_valid && !key_stall;
	assign pop       = out_valid_q && !res_stall;

	// Entry registers and command decode
	cde_ctrl #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.key       (key_data),
		.head_digit(digit[0]),
		.cmd       (cmd),
		.status    (status)
	);

	// Row of digit cells; the tail mark moves between neighbors
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		logic left_last, right_last;
		if (i == 0) begin : g_head
			assign left_last = 1'b0;
		end else begin : g_body
			assign left_last = last[i-1];
		end
		if (i == MAX_DIGITS - 1) begin : g_end
			assign right_last = 1'b0;
		end else begin : g_mid
			assign right_last = last[i+1];
		end
		cde_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.head      (i == 0),
			.left_last (left_last),
			.right_last(right_last),
			.last      (last[i]),
			.digit     (digit[i]),
			.digit_nxt (digit_nxt[i])
		);
	end

	// Assemble the result from the state after the key
	always_comb begin
		result.digits_packed = '0;
		for (int i = 0; i < NP; i++) begin
			result.digits_packed[DIGIT_W*i +: DIGIT_W] = digit_nxt[i];
		end
		result.digit_count    = status.digit_count;
		result.point_position = status.point_position;
		result.negative       = status.negative;
		result.entry_full     = status.entry_full;
	end

	// Output queue: fill the output register first, park in skid otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (!out_valid_q || pop) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

// ----- hdl/cde_check.sv -----
module cde_check #(
	parameter int MAX_DIGITS = 13
) (
	input logic             clk,
	input logic             arst_n,
	input logic             key_valid,
	input logic             key_stall,
	input cde_pkg::key_t    key_data,
	input logic             res_valid,
	input logic             res_stall,
	input cde_pkg::result_t res_data
);
	import cde_pkg::*;

	localparam bit EXACT = (MAX_DIGITS < 16);
	localparam bit FITS  = (MAX_DIGITS <= PACK_DIGITS);

	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_stall |=> key_valid && $stable(key_data))
		else $error("stalled key changed or dropped");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("stalled result changed");

	a_point_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && EXACT |->
			res_data.digit_count != 4'd0 &&
			res_data.point_position <= res_data.digit_count &&
			res_data.entry_full == (res_data.digit_count == 4'(MAX_DIGITS)))
		else $error("count, point or full flag inconsistent");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && FITS |->
			(res_data.digits_packed >> (DIGIT_W * res_data.digit_count)) == '0)
		else $error("digit beyond count not zero");

endmodule

bind calculator_digit_entry cde_check #(
	.MAX_DIGITS(MAX_DIGITS)
) u_cde_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.key_valid(key_valid),
	.key_stall(key_stall),
	.key_data (key_data),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);
